// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, quiet while reset is asserted.
`define LBVS_ASSERT_RST(lbl, ck, rst, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define LBVS_ASSERT_ALL(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== design/lbvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lbvs_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  localparam int WORDS_PER_BONE = 12;
  localparam int BONE_ID_W      = 8;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;

  // addr / 12 == (addr * 2731) >> 15 for any 12-bit addr
  localparam logic [23:0] ADDR_DIV_MUL   = 24'd2731;
  localparam int          ADDR_DIV_SHIFT = 15;

  localparam logic signed [18:0] ONE_Q16 = 19'sd65536;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic                 is_vertex;
    logic                 wr_ok;
    logic [3:0]           bank;
    logic [BONE_ID_W-1:0] row;
    logic [31:0]          value;
    logic [31:0]          bone_ids;
    logic [47:0]          weights;
    vec3_t                pos;
    vec3_t                nrm;
    logic                 last;
  } qitem_t;

  // add half an LSB, then floor to Q16.16
  function automatic logic signed [47:0] rnd16(input logic signed [63:0] x);
    logic signed [63:0] s;
    s = x + 64'sd32768;
    return s[63:16];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [55:0] x);
    if (x > 56'sd2147483647)
      return 32'h7FFF_FFFF;
    else if (x < -56'sd2147483648)
      return 32'h8000_0000;
    else
      return x[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/lbvs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we)
      mem[waddr] <= wdata;
    if (re)
      rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== design/lbvs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbvs_front #(
  parameter int BONE_COUNT = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_opcode,
  input  wire logic [31:0]    in_bone_ids,
  input  wire logic [47:0]    in_weights,
  input  wire logic [31:0]    in_pos_x,
  input  wire logic [31:0]    in_pos_y,
  input  wire logic [31:0]    in_pos_z,
  input  wire logic [31:0]    in_nrm_x,
  input  wire logic [31:0]    in_nrm_y,
  input  wire logic [31:0]    in_nrm_z,
  input  wire logic [11:0]    in_table_address,
  input  wire logic [31:0]    in_table_value,
  input  wire logic           in_last_vertex,
  output logic                q_valid,
  output lbvs_pkg::qitem_t    q_item,
  input  wire logic           q_pop
);

  localparam int TABLE_WORDS = BONE_COUNT * lbvs_pkg::WORDS_PER_BONE;

  lbvs_pkg::qitem_t               q_mem_r [lbvs_pkg::QUEUE_DEPTH];
  logic [lbvs_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [lbvs_pkg::QPTR_W:0]      count_r;
  logic                           push;
  logic [23:0]                    quot_full;
  logic [8:0]                     row9;
  logic [12:0]                    row_x12;
  lbvs_pkg::qitem_t               item;

  // split the word address into bone row and bank (addr % 12)
  always_comb begin
    quot_full = 24'(in_table_address) * lbvs_pkg::ADDR_DIV_MUL;
    row9      = quot_full[lbvs_pkg::ADDR_DIV_SHIFT +: 9];
    row_x12   = 13'(row9) * 13'(lbvs_pkg::WORDS_PER_BONE);
    item.is_vertex = (in_opcode == lbvs_pkg::OP_VERTEX);
    item.wr_ok     = (in_opcode == lbvs_pkg::OP_LOAD) &&
                     ({1'b0, in_table_address} < 13'(TABLE_WORDS));
    item.bank      = 4'(in_table_address - row_x12[11:0]);
    item.row       = row9[lbvs_pkg::BONE_ID_W-1:0];
    item.value     = in_table_value;
    item.bone_ids  = in_bone_ids;
    item.weights   = in_weights;
    item.pos       = {in_pos_z, in_pos_y, in_pos_x};
    item.nrm       = {in_nrm_z, in_nrm_y, in_nrm_x};
    item.last      = in_last_vertex;
  end

  assign in_ready = (count_r != (lbvs_pkg::QPTR_W + 1)'(lbvs_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push)
      q_mem_r[wr_ptr_r] <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop)
        rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !q_pop)
        count_r <= count_r + 1'b1;
      else if (!push && q_pop)
        count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== design/lbvs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbvs_back #(
  parameter int BONE_COUNT = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [2:0]     link_count,
  input  wire logic           q_valid,
  input  lbvs_pkg::qitem_t    q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [31:0]         out_skinned_pos_x,
  output logic [31:0]         out_skinned_pos_y,
  output logic [31:0]         out_skinned_pos_z,
  output logic [31:0]         out_skinned_nrm_x,
  output logic [31:0]         out_skinned_nrm_y,
  output logic [31:0]         out_skinned_nrm_z,
  output logic                out_batch_end
);

  localparam int BW  = $clog2(BONE_COUNT);
  localparam int NWD = lbvs_pkg::WORDS_PER_BONE;

  logic                  adv, issue_vtx, is_last_bone;
  logic [1:0]            lnk_m1, k_r;
  logic [7:0]            id_byte;
  logic [BW-1:0]         rd_bone;
  logic signed [18:0]    w0, w1, w2, wk, w_sel;
  logic [31:0]           mword [NWD];

  // issue -> S1
  logic                  s1_vld_r, s1_first_r, s1_last_r, s1_end_r;
  logic signed [18:0]    s1_w_r;
  lbvs_pkg::vec3_t       s1_pos_r, s1_nrm_r;
  // S2: raw products
  logic                  s2_vld_r, s2_first_r, s2_last_r, s2_end_r;
  logic signed [18:0]    s2_w_r;
  logic signed [63:0]    s2_pp_r [3][3];
  logic signed [63:0]    s2_np_r [3][3];
  logic signed [31:0]    s2_tr_r [3];
  // S3: per-bone vectors
  logic                  s3_vld_r, s3_first_r, s3_last_r, s3_end_r;
  logic signed [18:0]    s3_w_r;
  logic signed [31:0]    s3_tp_r [3];
  logic signed [31:0]    s3_tn_r [3];
  logic signed [49:0]    tp_sum [3];
  logic signed [49:0]    tn_sum [3];
  // S4: weighted vectors
  logic                  s4_vld_r, s4_first_r, s4_last_r, s4_end_r;
  logic signed [50:0]    s4_pp_r [3];
  logic signed [50:0]    s4_np_r [3];
  // S5: blend accumulators
  logic                  s5_vld_r, s5_end_r;
  logic signed [55:0]    acc_p_r [3];
  logic signed [55:0]    acc_n_r [3];
  logic signed [55:0]    accp_sum [3];
  logic signed [55:0]    accn_sum [3];
  // output word
  logic                  out_vld_r, out_end_r;
  logic [31:0]           out_p_r [3];
  logic [31:0]           out_n_r [3];

  // whole back end holds while a finished word waits
  assign adv = !out_vld_r || out_ready;

  always_comb begin
    unique case (link_count) inside
      3'd0, 3'd1: lnk_m1 = 2'd0;
      3'd2:       lnk_m1 = 2'd1;
      3'd3:       lnk_m1 = 2'd2;
      default:    lnk_m1 = 2'd3;
    endcase
  end

  assign is_last_bone = (k_r == lnk_m1);
  assign issue_vtx    = adv && q_valid && q_item.is_vertex;
  assign q_pop        = adv && q_valid && (!q_item.is_vertex || is_last_bone);

  always_comb begin
    id_byte = q_item.bone_ids[{k_r, 3'b000} +: 8];
    if ({1'b0, id_byte} < 9'(BONE_COUNT))
      rd_bone = BW'(id_byte);
    else
      rd_bone = BW'(BONE_COUNT - 1);
  end

  // bone weight: lerp is (1-w0, w0); last bone of 3/4 links takes the rest
  always_comb begin
    w0 = 19'(q_item.weights[15:0]);
    w1 = 19'(q_item.weights[31:16]);
    w2 = 19'(q_item.weights[47:32]);
    case (k_r)
      2'd0:    wk = w0;
      2'd1:    wk = w1;
      default: wk = w2;
    endcase
    if (lnk_m1 == 2'd0)
      w_sel = lbvs_pkg::ONE_Q16;
    else if (lnk_m1 == 2'd1)
      w_sel = (k_r == 2'd0) ? lbvs_pkg::ONE_Q16 - w0 : w0;
    else if (is_last_bone)
      w_sel = lbvs_pkg::ONE_Q16 - w0 - w1 - ((lnk_m1 == 2'd3) ? w2 : 19'sd0);
    else
      w_sel = wk;
  end

  for (genvar gi = 0; gi < NWD; gi++) begin : g_bank
    lbvs_ram #(
      .WIDTH (32),
      .DEPTH (BONE_COUNT)
    ) u_ram (
      .clk   (clk),
      .we    (adv && q_valid && !q_item.is_vertex && q_item.wr_ok &&
              (q_item.bank == 4'(gi))),
      .waddr (q_item.row[BW-1:0]),
      .wdata (q_item.value),
      .re    (adv),
      .raddr (rd_bone),
      .rdata (mword[gi])
    );
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tp_sum[c] = 50'(lbvs_pkg::rnd16(s2_pp_r[c][0])) + 50'(lbvs_pkg::rnd16(s2_pp_r[c][1]))
                + 50'(lbvs_pkg::rnd16(s2_pp_r[c][2])) + 50'(s2_tr_r[c]);
      tn_sum[c] = 50'(lbvs_pkg::rnd16(s2_np_r[c][0])) + 50'(lbvs_pkg::rnd16(s2_np_r[c][1]))
                + 50'(lbvs_pkg::rnd16(s2_np_r[c][2]));
      accp_sum[c] = (s4_first_r ? 56'sd0 : acc_p_r[c]) + 56'(s4_pp_r[c]);
      accn_sum[c] = (s4_first_r ? 56'sd0 : acc_n_r[c]) + 56'(s4_np_r[c]);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      if (issue_vtx)
        k_r <= is_last_bone ? 2'd0 : k_r + 2'd1;
      s1_vld_r  <= issue_vtx;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r && s4_last_r;
      out_vld_r <= s5_vld_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first_r <= (k_r == 2'd0);
      s1_last_r  <= is_last_bone;
      s1_end_r   <= q_item.last;
      s1_w_r     <= w_sel;
      s1_pos_r   <= q_item.pos;
      s1_nrm_r   <= q_item.nrm;

      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_end_r   <= s1_end_r;
      s2_w_r     <= s1_w_r;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          s2_pp_r[c][r] <= $signed(s1_pos_r[r]) * $signed(mword[r*3+c]);
          s2_np_r[c][r] <= $signed(s1_nrm_r[r]) * $signed(mword[r*3+c]);
        end
        s2_tr_r[c] <= $signed(mword[9+c]);
      end

      s3_first_r <= s2_first_r;
      s3_last_r  <= s2_last_r;
      s3_end_r   <= s2_end_r;
      s3_w_r     <= s2_w_r;
      for (int c = 0; c < 3; c++) begin
        s3_tp_r[c] <= $signed(lbvs_pkg::sat32(56'(tp_sum[c])));
        s3_tn_r[c] <= $signed(lbvs_pkg::sat32(56'(tn_sum[c])));
      end

      s4_first_r <= s3_first_r;
      s4_last_r  <= s3_last_r;
      s4_end_r   <= s3_end_r;
      for (int c = 0; c < 3; c++) begin
        s4_pp_r[c] <= s3_tp_r[c] * s3_w_r;
        s4_np_r[c] <= s3_tn_r[c] * s3_w_r;
      end

      if (s4_vld_r) begin
        for (int c = 0; c < 3; c++) begin
          acc_p_r[c] <= accp_sum[c];
          acc_n_r[c] <= accn_sum[c];
        end
      end
      s5_end_r <= s4_end_r;

      out_end_r <= s5_end_r;
      for (int c = 0; c < 3; c++) begin
        out_p_r[c] <= lbvs_pkg::sat32(56'(lbvs_pkg::rnd16(64'(acc_p_r[c]))));
        out_n_r[c] <= lbvs_pkg::sat32(56'(lbvs_pkg::rnd16(64'(acc_n_r[c]))));
      end
    end
  end

  assign out_valid         = out_vld_r;
  assign out_batch_end     = out_end_r;
  assign out_skinned_pos_x = out_p_r[0];
  assign out_skinned_pos_y = out_p_r[1];
  assign out_skinned_pos_z = out_p_r[2];
  assign out_skinned_nrm_x = out_n_r[0];
  assign out_skinned_nrm_y = out_n_r[1];
  assign out_skinned_nrm_z = out_n_r[2];

endmodule
`default_nettype wire

// ===== design/linear_blend_vertex_skinning.sv =====
// A load word is issued once and a vertex word once per link (1..4), since each
// of the 12 matrix banks reads one bone per cycle while the back end is not
// stalled. A 4-entry queue keeps accepting until it is full while the back end
// is busy or stalled. Reset (rst_n low, synchronous) empties the queue and
// pipeline and sets link_count to 1; the matrix table keeps its contents.
`timescale 1ns / 1ps
`default_nettype none
module linear_blend_vertex_skinning #(
  parameter int BONE_COUNT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_bone_ids,
  input  wire logic [47:0] in_weights,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_nrm_x,
  input  wire logic [31:0] in_nrm_y,
  input  wire logic [31:0] in_nrm_z,
  input  wire logic [11:0] in_table_address,
  input  wire logic [31:0] in_table_value,
  input  wire logic        in_last_vertex,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_skinned_pos_x,
  output logic [31:0]      out_skinned_pos_y,
  output logic [31:0]      out_skinned_pos_z,
  output logic [31:0]      out_skinned_nrm_x,
  output logic [31:0]      out_skinned_nrm_y,
  output logic [31:0]      out_skinned_nrm_z,
  output logic             out_batch_end
);

  logic [2:0]        link_count_r;
  logic              q_valid, q_pop;
  lbvs_pkg::qitem_t  q_item;

  always_ff @(posedge clk) begin
    if (!rst_n)
      link_count_r <= 3'd1;
    else if (cfg_wr_en)
      link_count_r <= cfg_wr_data;
  end

  lbvs_front #(
    .BONE_COUNT (BONE_COUNT)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_bone_ids      (in_bone_ids),
    .in_weights       (in_weights),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_nrm_x         (in_nrm_x),
    .in_nrm_y         (in_nrm_y),
    .in_nrm_z         (in_nrm_z),
    .in_table_address (in_table_address),
    .in_table_value   (in_table_value),
    .in_last_vertex   (in_last_vertex),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  lbvs_back #(
    .BONE_COUNT (BONE_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .link_count        (link_count_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_skinned_pos_x (out_skinned_pos_x),
    .out_skinned_pos_y (out_skinned_pos_y),
    .out_skinned_pos_z (out_skinned_pos_z),
    .out_skinned_nrm_x (out_skinned_nrm_x),
    .out_skinned_nrm_y (out_skinned_nrm_y),
    .out_skinned_nrm_z (out_skinned_nrm_z),
    .out_batch_end     (out_batch_end)
  );

endmodule
`default_nettype wire

// ===== design/lbvs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lbvs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_skinned_pos_x,
  input wire logic        out_batch_end
);

  // reset flushes the output word and empties the queue
  `LBVS_ASSERT_ALL(a_rst_out, clk, !rst_n |=> !out_valid, "output valid after reset")
  `LBVS_ASSERT_ALL(a_rst_rdy, clk, !rst_n |=> in_ready, "queue not empty after reset")
  `LBVS_ASSERT_RST(a_out_hold, clk, !rst_n, out_valid && !out_ready |=> out_valid, "word dropped")
  `LBVS_ASSERT_RST(a_out_stable, clk, !rst_n, out_valid && !out_ready |=> $stable(out_skinned_pos_x) && $stable(out_batch_end), "stalled word changed")

endmodule

bind linear_blend_vertex_skinning lbvs_checker u_lbvs_checker (.*);
`default_nettype wire

// ===== tb/sv/linear_blend_vertex_skinning_test.sv =====
`timescale 1ns / 1ps
module linear_blend_vertex_skinning_test;

  typedef struct {
    logic            op;
    logic [31:0]     ids;
    logic [47:0]     wts;
    lbvs_pkg::vec3_t pos;
    lbvs_pkg::vec3_t nrm;
    logic [11:0]     addr;
    logic [31:0]     value;
    logic            last;
  } word_t;

  typedef struct {
    lbvs_pkg::vec3_t pos;
    lbvs_pkg::vec3_t nrm;
    logic            last;
  } skinned_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [31:0] in_bone_ids;
  logic [47:0] in_weights;
  logic [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic [31:0] in_nrm_x, in_nrm_y, in_nrm_z;
  logic [11:0] in_table_address;
  logic [31:0] in_table_value;
  logic        in_last_vertex;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_skinned_pos_x, out_skinned_pos_y, out_skinned_pos_z;
  logic [31:0] out_skinned_nrm_x, out_skinned_nrm_y, out_skinned_nrm_z;
  logic        out_batch_end;

  linear_blend_vertex_skinning dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_bone_ids(in_bone_ids), .in_weights(in_weights),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_nrm_x(in_nrm_x), .in_nrm_y(in_nrm_y), .in_nrm_z(in_nrm_z),
    .in_table_address(in_table_address), .in_table_value(in_table_value),
    .in_last_vertex(in_last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_skinned_pos_x(out_skinned_pos_x), .out_skinned_pos_y(out_skinned_pos_y),
    .out_skinned_pos_z(out_skinned_pos_z), .out_skinned_nrm_x(out_skinned_nrm_x),
    .out_skinned_nrm_y(out_skinned_nrm_y), .out_skinned_nrm_z(out_skinned_nrm_z),
    .out_batch_end(out_batch_end)
  );

  localparam int NBONES = 256;
  localparam int NWORDS = NBONES * lbvs_pkg::WORDS_PER_BONE;

  // predictor state
  int       bone_table [NWORDS];
  int       links_now;
  skinned_t skinned_q[$];

  // generator state: which table words the stimulus has written so far
  bit       gen_written [NWORDS];
  int       gen_links;
  int       ready_bones[$];

  word_t    pend_q[$];
  word_t    cur;
  bit       taken;
  int       idle_pct, stall_pct;
  int       n_pushed, n_accepted, n_vertices, n_loads, n_errors;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint rnd_q16(longint x);
    longint s;
    s = x + 64'sd32768;
    return s >>> 16;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint bone_xform(int b, lbvs_pkg::vec3_t v, bit with_t, int c);
    longint acc;
    acc = 0;
    for (int r = 0; r < 3; r++)
      acc += rnd_q16(longint'($signed(v[r])) * longint'(bone_table[b*12 + r*3 + c]));
    if (with_t) acc += longint'(bone_table[b*12 + 9 + c]);
    return clamp32(acc);
  endfunction

  function automatic logic [31:0] blend_vertex(logic [31:0] ids, logic [47:0] wts,
                                               int links, lbvs_pkg::vec3_t v,
                                               bit with_t, int c);
    longint t[4];
    longint w[4];
    longint rest, acc;
    int b0, b1;
    rest = 65536;
    acc = 0;
    b0 = int'(ids[7:0]);
    b1 = int'(ids[15:8]);
    if (links == 1) return 32'(bone_xform(b0, v, with_t, c));
    if (links == 2) begin
      t[0] = bone_xform(b0, v, with_t, c);
      if (b0 == b1) return 32'(t[0]);
      t[1] = bone_xform(b1, v, with_t, c);
      return 32'(clamp32(t[0] + rnd_q16((t[1] - t[0]) * longint'(wts[15:0]))));
    end
    for (int k = 0; k < links; k++) begin
      t[k] = bone_xform(int'(ids[8*k +: 8]), v, with_t, c);
      if (k + 1 < links) begin
        w[k] = longint'(wts[16*k +: 16]);
        rest -= w[k];
      end else begin
        w[k] = rest;
      end
      acc += t[k] * w[k];
    end
    return 32'(clamp32(rnd_q16(acc)));
  endfunction

  // driver
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!in_valid || taken) begin
      taken = 1'b0;
      if (pend_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur = pend_q.pop_front();
        in_valid         <= 1'b1;
        in_opcode        <= cur.op;
        in_bone_ids      <= cur.ids;
        in_weights       <= cur.wts;
        in_pos_x         <= cur.pos[0];
        in_pos_y         <= cur.pos[1];
        in_pos_z         <= cur.pos[2];
        in_nrm_x         <= cur.nrm[0];
        in_nrm_y         <= cur.nrm[1];
        in_nrm_z         <= cur.nrm[2];
        in_table_address <= cur.addr;
        in_table_value   <= cur.value;
        in_last_vertex   <= cur.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted input word, check on accepted output word
  always @(posedge clk) begin
    skinned_t        e;
    lbvs_pkg::vec3_t got_p, got_n;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        taken = 1'b1;
        n_accepted++;
        if (cur.op == lbvs_pkg::OP_LOAD) begin
          if (cur.addr < NWORDS) bone_table[cur.addr] = cur.value;
        end else begin
          for (int c = 0; c < 3; c++) begin
            e.pos[c] = blend_vertex(cur.ids, cur.wts, links_now, cur.pos, 1'b1, c);
            e.nrm[c] = blend_vertex(cur.ids, cur.wts, links_now, cur.nrm, 1'b0, c);
          end
          e.last = cur.last;
          skinned_q.insert(skinned_q.size(), e);
        end
      end
      if (out_valid && out_ready) begin
        got_p = {out_skinned_pos_z, out_skinned_pos_y, out_skinned_pos_x};
        got_n = {out_skinned_nrm_z, out_skinned_nrm_y, out_skinned_nrm_x};
        if (skinned_q.size() == 0) begin
          $error("output word with nothing expected");
          n_errors++;
        end else begin
          e = skinned_q.pop_front();
          n_vertices++;
          for (int c = 0; c < 3; c++) begin
            if (got_p[c] !== e.pos[c]) begin
              $error("skinned_pos[%0d]: expected %h, got %h", c, e.pos[c], got_p[c]);
              n_errors++;
            end
            if (got_n[c] !== e.nrm[c]) begin
              $error("skinned_nrm[%0d]: expected %h, got %h", c, e.nrm[c], got_n[c]);
              n_errors++;
            end
          end
          if (out_batch_end !== e.last) begin
            $error("batch_end: expected %b, got %b", e.last, out_batch_end);
            n_errors++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] pick_val(bit narrow);
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return 32'h0;
      default: return narrow ? 32'($signed($urandom_range(262143)) - 131072) : $urandom;
    endcase
  endfunction

  task automatic push_load(int addr, logic [31:0] val);
    word_t wd;
    wd.op    = lbvs_pkg::OP_LOAD;
    wd.ids   = $urandom;
    wd.wts   = 48'({$urandom, $urandom});
    for (int c = 0; c < 3; c++) begin
      wd.pos[c] = $urandom;
      wd.nrm[c] = $urandom;
    end
    wd.addr  = 12'(addr);
    wd.value = val;
    wd.last  = 1'($urandom_range(1));
    pend_q.insert(pend_q.size(), wd);
    n_pushed++;
    n_loads++;
    if (addr < NWORDS && !gen_written[addr]) begin
      bit full;
      gen_written[addr] = 1'b1;
      full = 1'b1;
      for (int i = 0; i < 12; i++)
        if (!gen_written[(addr / 12) * 12 + i]) full = 1'b0;
      if (full) ready_bones.insert(ready_bones.size(), addr / 12);
    end
  endtask

  task automatic push_bone(int b, bit narrow);
    for (int i = 0; i < 12; i++) push_load(b * 12 + i, pick_val(narrow));
  endtask

  task automatic push_vertex(bit extreme);
    word_t wd;
    int eff;
    eff = (gen_links < 1) ? 1 : (gen_links > 4) ? 4 : gen_links;
    wd.op = lbvs_pkg::OP_VERTEX;
    wd.ids = $urandom;
    for (int k = 0; k < eff; k++)
      wd.ids[8*k +: 8] = 8'(ready_bones[$urandom_range(ready_bones.size() - 1)]);
    if (eff >= 2 && $urandom_range(7) == 0) wd.ids[15:8] = wd.ids[7:0];
    wd.wts = 48'({$urandom, $urandom});
    for (int k = 0; k < 3; k++)
      case ($urandom_range(5))
        0: wd.wts[16*k +: 16] = 16'h0;
        1: wd.wts[16*k +: 16] = 16'hFFFF;
        default: ;
      endcase
    for (int c = 0; c < 3; c++) begin
      if (extreme) begin
        wd.pos[c] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        wd.nrm[c] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else begin
        wd.pos[c] = pick_val($urandom_range(2) != 0);
        wd.nrm[c] = pick_val($urandom_range(2) != 0);
      end
    end
    wd.addr  = 12'($urandom);
    wd.value = $urandom;
    wd.last  = ($urandom_range(7) == 0);
    pend_q.insert(pend_q.size(), wd);
    n_pushed++;
  endtask

  task automatic wait_drained();
    while (n_accepted < n_pushed || skinned_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_links(int v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 3'(v);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    links_now = v;
    gen_links = v;
    links_now = (v < 1) ? 1 : (v > 4) ? 4 : v;
  endtask

  initial begin
    int phase_links[12] = '{1, 2, 3, 4, 0, 5, 6, 7, 2, 3, 4, 1};
    int idle_mode[4][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{36, 36}};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_opcode = lbvs_pkg::OP_LOAD;
    in_bone_ids = '0;
    in_weights = '0;
    {in_pos_x, in_pos_y, in_pos_z, in_nrm_x, in_nrm_y, in_nrm_z} = '0;
    in_table_address = '0;
    in_table_value = '0;
    in_last_vertex = 1'b0;
    out_ready = 1'b0;
    taken = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    links_now = 1;
    gen_links = 1;
    n_pushed = 0; n_accepted = 0; n_vertices = 0; n_loads = 0; n_errors = 0;
    foreach (bone_table[i]) bone_table[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table setup: identity, extremes, the top bone, bones 2..7 and out-of-range addresses
    for (int i = 0; i < 12; i++) push_load(i, (i == 0 || i == 4 || i == 8) ? 32'h1_0000 : 0);
    for (int i = 0; i < 12; i++) push_load(12 + i, i[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
    push_bone(255, 1'b0);
    for (int b = 2; b < 8; b++) push_bone(b, b < 5);
    push_load(3072, 32'hDEAD_BEEF);   // past the table, dropped
    push_load(4095, 32'h1234_5678);
    push_load(3072 + 5, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      write_links(phase_links[ph]);
      idle_pct  = idle_mode[ph % 4][0];
      stall_pct = idle_mode[ph % 4][1];
      push_vertex(1'b1);
      push_vertex(1'b1);
      for (int n = 0; n < 30; n++) begin
        case ($urandom_range(19))
          0: push_load($urandom_range(4095), pick_val(1'b0));
          1: push_load(ready_bones[$urandom_range(ready_bones.size() - 1)] * 12
                       + $urandom_range(11), pick_val($urandom_range(1)));
          2: push_bone($urandom_range(NBONES - 1), $urandom_range(1));
          default: push_vertex(1'b0);
        endcase
      end
    end
    wait_drained();

    $display("Checked %0d skinned vertices over %0d table loads, link counts 0..7,",
             n_vertices, n_loads);
    $display("under no idling, heavy sender gaps, heavy output stalls and both.");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
